### hdl/periodic_task_slot_timer_defines.svh
// periodic_task_slot_timer_defines.svh: assertion macros for the slot timer checker
// needs a clk and an active low rst_n in the scope of use
`ifndef PERIODIC_TASK_SLOT_TIMER_DEFINES_SVH
`define PERIODIC_TASK_SLOT_TIMER_DEFINES_SVH

// checked only while out of reset
`define PTST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every edge, reset included
`define PTST_ASSERT_RESET(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ptst_pkg.sv
// ptst_pkg: types, codes and constants of the periodic task slot timer
// no dependencies
package ptst_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int MAX_FIRES   = 16;
  localparam int FIRE_W      = $clog2(MAX_FIRES + 1);
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [2:0] {
    K_TICK        = 3'd0,
    K_REGISTER    = 3'd1,
    K_DROP_HANDLE = 3'd2,
    K_DROP_SLOT   = 3'd3,
    K_RESET_TICKS = 3'd4,
    K_SET_PERIOD  = 3'd5,
    K_TRIGGER     = 3'd6,
    K_PROCESS     = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] ctx;
    logic [15:0] period;
    logic [15:0] ticks;
  } slot_entry_t;

  typedef struct packed {
    logic        fire;
    logic [3:0]  slot;
    logic [15:0] handle;
    logic [15:0] ctx;
    status_t     status;
  } res_t;

  typedef struct packed {
    logic we;
    logic clr;
    logic re;
  } mem_ctl_t;

endpackage

### hdl/ptst_slot_mem.sv
// ptst_slot_mem: slot table memory, one write and one registered read port
// entries carry valid bits so that a slot never written or dropped reads as zero; uses ptst_pkg
module ptst_slot_mem #(
  parameter int SLOTS  = ptst_pkg::SLOTS_DEF,
  parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ptst_pkg::mem_ctl_t    ctl,
  input  logic [SLOT_W-1:0]     waddr,
  input  ptst_pkg::slot_entry_t wdata,
  input  logic [SLOT_W-1:0]     raddr,
  output ptst_pkg::slot_entry_t rdata
);
  import ptst_pkg::*;

  slot_entry_t           mem_q [SLOTS];
  logic [SLOTS-1:0]      vld_r;
  slot_entry_t           rd_q;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem_q[waddr] <= wdata;
    end
    if (ctl.re) begin
      rd_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.re) begin
        rd_vld_r <= vld_r[raddr];
      end
      if (ctl.we) begin
        vld_r[waddr] <= 1'b1;
      end else if (ctl.clr) begin
        vld_r[waddr] <= 1'b0;
      end
    end
  end

  assign rdata = rd_vld_r ? rd_q : '0;

endmodule

### hdl/periodic_task_slot_timer.sv
// periodic_task_slot_timer: top level, command sequencer around the slot table
// uses ptst_pkg and ptst_slot_mem
//
// usage
// - one request on the in_ channel is one command: tick, register, drop by handle,
//   drop by slot, reset ticks, set interval, trigger or process (kind on in_tuser)
// - every request gives one or more results on the out_ channel, the final one with
//   out_tlast; out_tuser flags a fire, otherwise the result carries a status
// - tick, drop by handle and process walk the registered slots, one slot per cycle
//   through the table memory read port, unless a process walk stalls on its output;
//   drop by handle stops at its match
// - trigger, reset ticks and set interval read one slot; register and drop by slot
//   read none
// - a walk that finds due slots holds each fire until the next one is found, so the
//   last fire can carry out_tlast
// - a stalled receiver stalls the walk only when a second fire must go out; the output
//   register lets the next request in while the last result waits
// - reset empties the table through per slot valid bits and clears the millisecond
//   count; no clearing pass, the first request is taken right after reset
module periodic_task_slot_timer #(
  parameter int SLOTS = ptst_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // slot_id[3:0], handle[19:4], context_req[35:20], period[51:36], zero pad
  input  logic [ptst_pkg::IN_TDATA_W-1:0]     in_tdata,
  // kind[2:0]
  input  logic [2:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_slot[3:0], out_handle[19:4], out_context[35:20], status[37:36],
  // now_ms[69:38], zero pad
  output logic [ptst_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // fire[0]
  output logic [0:0]                          out_tuser,
  output logic                                out_tlast
);
  import ptst_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [31:0]             millis_r, millis_nxt;
  res_t                    res_r, res_nxt;
  logic                    res_vld_r, res_vld_nxt;
  logic [FIRE_W-1:0]       fire_cnt_r, fire_cnt_nxt;
  logic [SLOT_W-1:0]       eval_idx_r, eval_idx_nxt;
  logic [SLOT_W-1:0]       end_idx_r, end_idx_nxt;
  kind_t                   cmd_kind_r, cmd_kind_nxt;
  logic [15:0]             cmd_handle_r, cmd_handle_nxt;
  logic [15:0]             cmd_period_r, cmd_period_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;
  logic                    out_fire_r, out_fire_nxt;
  logic                    out_last_r, out_last_nxt;

  kind_t                   in_kind;
  logic [3:0]              in_sid;
  logic [15:0]             in_handle;
  logic [15:0]             in_ctx;
  logic [15:0]             in_period;
  logic                    sid_ok;
  logic [SLOT_W-1:0]       sid_idx;

  mem_ctl_t                ctl;
  logic [SLOT_W-1:0]       waddr;
  logic [SLOT_W-1:0]       raddr;
  slot_entry_t             wdata;
  slot_entry_t             ent;

  logic                    out_free;
  logic                    push;
  res_t                    push_res;
  logic                    push_last;
  logic                    act;
  logic                    stall;
  logic                    stop;

  assign in_kind   = kind_t'(in_tuser);
  assign in_sid    = in_tdata[3:0];
  assign in_handle = in_tdata[19:4];
  assign in_ctx    = in_tdata[35:20];
  assign in_period = in_tdata[51:36];
  assign sid_ok    = 32'(in_sid) < SLOTS;
  assign sid_idx   = SLOT_W'(in_sid);

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign act       = (ent.handle != 16'd0);

  ptst_slot_mem #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ent)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    millis_nxt     = millis_r;
    res_nxt        = res_r;
    res_vld_nxt    = res_vld_r;
    fire_cnt_nxt   = fire_cnt_r;
    eval_idx_nxt   = eval_idx_r;
    end_idx_nxt    = end_idx_r;
    cmd_kind_nxt   = cmd_kind_r;
    cmd_handle_nxt = cmd_handle_r;
    cmd_period_nxt = cmd_period_r;
    ctl            = '0;
    waddr          = eval_idx_r;
    raddr          = eval_idx_r;
    wdata          = ent;
    push           = 1'b0;
    push_res       = res_r;
    push_last      = 1'b0;
    stall          = 1'b0;
    stop           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_kind_nxt   = in_kind;
          cmd_handle_nxt = in_handle;
          cmd_period_nxt = in_period;
          res_nxt        = '0;
          res_vld_nxt    = 1'b0;
          fire_cnt_nxt   = '0;
          state_nxt      = S_DONE;
          unique case (in_kind)
            K_TICK, K_DROP_HANDLE, K_PROCESS: begin
              if (in_kind == K_TICK) begin
                millis_nxt = millis_r + 32'd1;
              end
              if (in_kind == K_DROP_HANDLE) begin
                res_nxt.status = ST_NOT_FOUND;
              end
              if (cnt_r != '0) begin
                ctl.re       = 1'b1;
                raddr        = '0;
                eval_idx_nxt = '0;
                end_idx_nxt  = SLOT_W'(cnt_r - CNT_W'(1));
                state_nxt    = S_SCAN;
              end
            end
            K_REGISTER: begin
              if (cnt_r == CNT_W'(SLOTS)) begin
                res_nxt.status = ST_FULL;
              end else begin
                ctl.we       = 1'b1;
                waddr        = cnt_r[SLOT_W-1:0];
                wdata        = '{handle: in_handle, ctx: in_ctx, period: in_period,
                                 ticks: 16'd0};
                res_nxt.slot = 4'(cnt_r);
                cnt_nxt      = cnt_r + CNT_W'(1);
              end
            end
            K_DROP_SLOT: begin
              if (sid_ok) begin
                ctl.clr = 1'b1;
                waddr   = sid_idx;
              end
            end
            default: begin
              if (sid_ok) begin
                ctl.re       = 1'b1;
                raddr        = sid_idx;
                eval_idx_nxt = sid_idx;
                end_idx_nxt  = sid_idx;
                state_nxt    = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        unique case (cmd_kind_r)
          K_TICK: begin
            if (act && ent.ticks != 16'hFFFF) begin
              ctl.we      = 1'b1;
              wdata.ticks = ent.ticks + 16'd1;
            end
          end
          K_DROP_HANDLE: begin
            if (ent.handle == cmd_handle_r) begin
              ctl.clr        = 1'b1;
              res_nxt.slot   = 4'(eval_idx_r);
              res_nxt.status = ST_OK;
              stop           = 1'b1;
            end
          end
          K_RESET_TICKS: begin
            if (act) begin
              ctl.we      = 1'b1;
              wdata.ticks = 16'd0;
            end
          end
          K_SET_PERIOD: begin
            if (act) begin
              ctl.we       = 1'b1;
              wdata.period = cmd_period_r;
            end
          end
          K_TRIGGER, K_PROCESS: begin
            if (act && (cmd_kind_r == K_TRIGGER || ent.ticks >= ent.period)) begin
              if (res_vld_r && !out_free) begin
                stall = 1'b1;
              end else begin
                push         = res_vld_r;
                res_nxt      = '{fire: 1'b1, slot: 4'(eval_idx_r), handle: ent.handle,
                                 ctx: ent.ctx, status: ST_OK};
                res_vld_nxt  = 1'b1;
                ctl.we       = 1'b1;
                wdata.ticks  = 16'd0;
                fire_cnt_nxt = fire_cnt_r + FIRE_W'(1);
                stop         = (fire_cnt_r == FIRE_W'(MAX_FIRES - 1));
              end
            end
          end
          default: begin
          end
        endcase
        if (!stall) begin
          if (stop || eval_idx_r == end_idx_r) begin
            state_nxt = S_DONE;
          end else begin
            ctl.re       = 1'b1;
            raddr        = eval_idx_r + SLOT_W'(1);
            eval_idx_nxt = eval_idx_r + SLOT_W'(1);
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          push        = 1'b1;
          push_last   = 1'b1;
          res_vld_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_fire_nxt  = out_fire_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {2'b00, millis_r, push_res.status, push_res.ctx, push_res.handle,
                       push_res.slot};
      out_fire_nxt  = push_res.fire;
      out_last_nxt  = push_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      millis_r    <= '0;
      res_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      millis_r    <= millis_nxt;
      res_vld_r   <= res_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r        <= res_nxt;
    fire_cnt_r   <= fire_cnt_nxt;
    eval_idx_r   <= eval_idx_nxt;
    end_idx_r    <= end_idx_nxt;
    cmd_kind_r   <= cmd_kind_nxt;
    cmd_handle_r <= cmd_handle_nxt;
    cmd_period_r <= cmd_period_nxt;
    out_data_r   <= out_data_nxt;
    out_fire_r   <= out_fire_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_fire_r;
  assign out_tlast    = out_last_r;

endmodule

### hdl/ptst_checker.sv
// ptst_checker.sv: ptst_port_checks, port level checks of periodic_task_slot_timer,
// bound to the top level; uses ptst_pkg and the macros of periodic_task_slot_timer_defines.svh
`include "periodic_task_slot_timer_defines.svh"

module ptst_port_checks (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [ptst_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [0:0]                         out_tuser,
  input logic                               out_tlast
);

  // empty output and ready input right after reset
  `PTST_ASSERT_RESET(a_reset_idle, !rst_n |=> !out_tvalid && in_tready, "not idle after reset")

  // a stalled result holds
  `PTST_ASSERT(a_out_hold,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast),
    "stalled result changed")

  // one request at a time
  `PTST_ASSERT(a_busy_after_req, in_tvalid && in_tready |=> !in_tready, "request taken while busy")

  // a fire always carries ok status
  `PTST_ASSERT(a_fire_status,
    out_tvalid && out_tuser[0] |-> out_tdata[37:36] == 2'b00,
    "fire with error status")

  // a status result carries no task
  `PTST_ASSERT(a_status_clean,
    out_tvalid && !out_tuser[0] |-> out_tdata[35:4] == 32'd0,
    "status result with task data")

endmodule

bind periodic_task_slot_timer ptst_port_checks u_ptst_port_checks (.*);
